[src/assert_macros.svh]
// Assertion macros used by the RTL controller (mdt_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/mdt_pkg.sv]
// Package: shared types and constants of the motion deadband tracker.
`timescale 1ns / 1ps
package mdt_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SqW    = 66;   // sum of three 33-bit squares
  localparam int unsigned RootW  = 34;
  localparam logic [31:0] DeadbandReset = 32'd655;

  typedef enum logic [1:0] {
    SelStep = 2'd0,
    SelRadNew = 2'd1,
    SelRadOld = 2'd2
  } dist_sel_e;

  // controller to datapath
  typedef struct packed {
    logic      load;       // capture input item
    logic      sq_start;   // begin accumulating sum of squares
    logic [1:0] axis;      // axis whose square is added
    logic      sq_add;     // add one square
    dist_sel_e sel;        // operand pair for distance
    logic      rt_start;   // begin root
    logic      rt_step;    // one root bit
    logic      save;       // save root to result slot sel
    logic      finish;     // form result, update state
  } mdt_cmd_t;

  typedef struct packed {
    logic rebase;
    logic rt_last;
  } mdt_sts_t;
endpackage

[src/mdt_ctrl.sv]
// Controller: sequences squares, roots and the final update for one item.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mdt_pkg::mdt_cmd_t cmd_o,
  input  mdt_pkg::mdt_sts_t sts_i
);
  import mdt_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StSq, StRoot, StFin, StOut
  } state_e;

  state_e    state_q;
  logic [1:0] axis_q;
  dist_sel_e sel_q;
  logic      out_valid_q;

  assign in_ready  = (state_q == StIdle);
  assign out_valid = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = sel_q;
    cmd_o.axis = axis_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = in_valid;
      end
      StSq: begin
        cmd_o.sq_add = 1'b1;
        cmd_o.sq_start = (axis_q == 2'd0);
        cmd_o.rt_start = (axis_q == 2'd2);
      end
      StRoot: begin
        cmd_o.rt_step = 1'b1;
        cmd_o.save = sts_i.rt_last;
      end
      StFin: begin
        cmd_o.finish = 1'b1;
      end
      StOut: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q <= 2'd0;
      sel_q <= SelStep;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid) begin
            state_q <= StSq;
            axis_q <= 2'd0;
            sel_q <= SelStep;
          end
        end
        StSq: begin
          if (sts_i.rebase) begin
            state_q <= StFin;
          end else if (axis_q == 2'd2) begin
            axis_q <= 2'd0;
            state_q <= StRoot;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StRoot: begin
          if (sts_i.rt_last) begin
            if (sel_q == SelRadOld) begin
              state_q <= StFin;
            end else begin
              sel_q <= (sel_q == SelStep) ? SelRadNew : SelRadOld;
              state_q <= StSq;
            end
          end
        end
        StFin: begin
          state_q <= StOut;
          out_valid_q <= 1'b1;
        end
        StOut: begin
          if (out_ready) begin
            out_valid_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_no_out, clk_i, rst_ni, in_ready, !out_valid)
  `ASSERT_NEXT(a_fin_out, clk_i, rst_ni, cmd_o.finish, out_valid)
  `ASSERT_IMPL(a_save_root, clk_i, rst_ni, cmd_o.save, state_q == StRoot)
endmodule

[src/mdt_dp.sv]
// Datapath: held state, square accumulator, bit-serial root and results.
`timescale 1ns / 1ps
module mdt_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mdt_pkg::mdt_cmd_t        cmd_i,
  output mdt_pkg::mdt_sts_t        sts_o,
  input  logic                     cfg_we_i,
  input  logic [31:0]              cfg_wdata_i,
  input  logic                     mode_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic [4:0]               rebase_mask_i,
  output logic [33:0]              step_distance_o,
  output logic signed [34:0]       radial_change_o,
  output logic signed [32:0]       delta_x_o,
  output logic signed [32:0]       delta_y_o,
  output logic signed [32:0]       delta_z_o
);
  import mdt_pkg::*;

  logic [31:0] db_q;
  logic mode_q;
  logic [4:0] mask_q;
  logic signed [31:0] p_q [3];
  logic signed [31:0] hs_q [3];
  logic signed [31:0] hr_q [3];
  logic signed [31:0] ref_q [3];
  logic signed [31:0] hx_q, hy_q, hz_q;
  logic [SqW-1:0] acc_q;
  // root: classic remainder method, one bit a cycle
  logic [SqW+1:0] rem_q;
  logic [SqW-1:0] src_q;
  logic [RootW-1:0] root_q;
  logic [5:0] bit_q;
  logic [RootW-1:0] d_step_q, d_rn_q, d_ro_q;
  logic [33:0] so_q;
  logic signed [34:0] ro_q;
  logic signed [32:0] dx_q, dy_q, dz_q;

  // operand difference for the square
  logic signed [31:0] a_op, b_op;
  logic signed [32:0] diff;
  logic [32:0] dmag;
  logic [SqW-1:0] sq;
  always_comb begin
    unique case (cmd_i.sel)
      SelStep:   begin a_op = hs_q[cmd_i.axis];  b_op = p_q[cmd_i.axis]; end
      SelRadNew: begin a_op = p_q[cmd_i.axis];   b_op = ref_q[cmd_i.axis]; end
      default:   begin a_op = hr_q[cmd_i.axis];  b_op = ref_q[cmd_i.axis]; end
    endcase
    diff = 33'(a_op) - 33'(b_op);
    dmag = diff[32] ? 33'(-diff) : 33'(diff);
    sq = SqW'(dmag) * SqW'(dmag);
  end

  logic [SqW-1:0] acc_n;
  assign acc_n = (cmd_i.sq_start ? '0 : acc_q) + sq;

  logic [SqW+1:0] trial, rem_sh;
  assign rem_sh = {rem_q[SqW-1:0], src_q[SqW-1 -: 2]};
  assign trial = (SqW+2)'({root_q[RootW-1:0], 2'b01});

  assign sts_o.rebase = mode_q;
  assign sts_o.rt_last = (bit_q == 6'd0);

  logic signed [34:0] rc;
  logic [34:0] rcmag;
  logic signed [32:0] ex, ey, ez;
  logic [32:0] mx, my, mz;
  always_comb begin
    rc = $signed({1'b0, d_rn_q}) - $signed({1'b0, d_ro_q});
    rcmag = rc[34] ? 35'(-rc) : 35'(rc);
    ex = 33'(p_q[0]) - 33'(hx_q);
    ey = 33'(p_q[1]) - 33'(hy_q);
    ez = 33'(p_q[2]) - 33'(hz_q);
    mx = ex[32] ? 33'(-ex) : 33'(ex);
    my = ey[32] ? 33'(-ey) : 33'(ey);
    mz = ez[32] ? 33'(-ez) : 33'(ez);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q <= DeadbandReset;
      for (int i = 0; i < 3; i++) begin
        hs_q[i] <= '0; hr_q[i] <= '0; ref_q[i] <= '0;
      end
      hx_q <= '0; hy_q <= '0; hz_q <= '0;
    end else begin
      if (cfg_we_i) db_q <= cfg_wdata_i;
      if (cmd_i.finish) begin
        if (mode_q) begin
          for (int i = 0; i < 3; i++) begin
            if (mask_q[0]) hs_q[i] <= p_q[i];
            if (mask_q[1]) begin ref_q[i] <= p_q[i]; hr_q[i] <= p_q[i]; end
          end
          if (mask_q[2]) hy_q <= p_q[1];
          if (mask_q[3]) hx_q <= p_q[0];
          if (mask_q[4]) hz_q <= p_q[2];
        end else begin
          if ({2'b0, d_step_q} > {4'b0, db_q})
            for (int i = 0; i < 3; i++) hs_q[i] <= p_q[i];
          if (rcmag > {3'b0, db_q})
            for (int i = 0; i < 3; i++) hr_q[i] <= p_q[i];
          if (mx > {1'b0, db_q}) hx_q <= p_q[0];
          if (my > {1'b0, db_q}) hy_q <= p_q[1];
          if (mz > {1'b0, db_q}) hz_q <= p_q[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i; mask_q <= rebase_mask_i;
      p_q[0] <= pos_x_i; p_q[1] <= pos_y_i; p_q[2] <= pos_z_i;
    end
    if (cmd_i.sq_add) acc_q <= acc_n;
    if (cmd_i.rt_start) begin
      // one root bit per pair of sum bits
      src_q <= acc_n; rem_q <= '0; root_q <= '0; bit_q <= 6'(SqW / 2 - 1);
    end else if (cmd_i.rt_step) begin
      src_q <= {src_q[SqW-3:0], 2'b00};
      bit_q <= bit_q - 6'd1;
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.save) begin
      unique case (cmd_i.sel)
        SelStep:   d_step_q <= {root_q[RootW-2:0], (rem_sh >= trial)};
        SelRadNew: d_rn_q   <= {root_q[RootW-2:0], (rem_sh >= trial)};
        default:   d_ro_q   <= {root_q[RootW-2:0], (rem_sh >= trial)};
      endcase
    end
    if (cmd_i.finish) begin
      so_q <= '0; ro_q <= '0; dx_q <= '0; dy_q <= '0; dz_q <= '0;
      if (!mode_q) begin
        if ({2'b0, d_step_q} > {4'b0, db_q}) so_q <= d_step_q;
        if (rcmag > {3'b0, db_q}) ro_q <= rc;
        if (mx > {1'b0, db_q}) dx_q <= ex;
        if (my > {1'b0, db_q}) dy_q <= ey;
        if (mz > {1'b0, db_q}) dz_q <= ez;
      end
    end
  end

  assign step_distance_o = so_q;
  assign radial_change_o = ro_q;
  assign delta_x_o = dx_q;
  assign delta_y_o = dy_q;
  assign delta_z_o = dz_q;
endmodule

[src/motion_deadband_tracker_top.sv]
// Top level of the motion deadband tracker.
`timescale 1ns / 1ps
// Motion deadband tracker.
// Input channel (in_valid/in_ready) takes one item: mode, pos_x/y/z, rebase_mask.
// Output channel (out_valid/out_ready) gives one result item per input item:
// step distance, radial change and x/y/z deltas, each zero inside the deadband and all zero for a rebase item.
// cfg_we_i/cfg_wdata_i write the deadband (unsigned Q16.16), no wait.
// One item at a time: for a sample, out_valid rises after three passes of square
// accumulation over the axes and bit-serial root, then a finish step; a rebase item
// goes from its first square state straight to the finish step. The sample's run
// is set by the one shared bit-serial square root unit, reused for the step, new
// radial and old radial distances; no new item is taken before the result is out.
// in_ready is high only while idle; results stay in registers until taken,
// so a stalled receiver holds the block with the result stable.
// Reset clears held positions, reference point and drops out_valid;
// the deadband returns to 655 (0.01).
module motion_deadband_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [4:0]         rebase_mask_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [33:0]        step_distance_o,
  output logic signed [34:0] radial_change_o,
  output logic signed [32:0] delta_x_o,
  output logic signed [32:0] delta_y_o,
  output logic signed [32:0] delta_z_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import mdt_pkg::*;

  mdt_cmd_t cmd;
  mdt_sts_t sts;

  mdt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd_o(cmd), .sts_i(sts)
  );

  mdt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_wdata_i,
    .mode_i, .pos_x_i, .pos_y_i, .pos_z_i, .rebase_mask_i,
    .step_distance_o, .radial_change_o, .delta_x_o, .delta_y_o, .delta_z_o
  );
endmodule

[verif/tb_top.sv]
// Testbench for the motion deadband tracker: random and directed items, scoreboard check.
`timescale 1ns / 1ps
module tb_top;
  import mdt_pkg::*;

  localparam int unsigned LimitCycles = 2000000;

  // one input item of the tracker
  typedef struct {
    logic             mode;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [4:0]       mask;
  } sample_t;

  // one result item of the tracker
  typedef struct {
    logic [33:0]        step;
    logic signed [34:0] radial;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } motion_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode_i = 1'b0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic [4:0] rebase_mask_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [33:0] step_distance_o;
  logic signed [34:0] radial_change_o;
  logic signed [32:0] delta_x_o;
  logic signed [32:0] delta_y_o;
  logic signed [32:0] delta_z_o;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  motion_deadband_tracker_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode_i         (mode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .rebase_mask_i  (rebase_mask_i),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .step_distance_o(step_distance_o),
    .radial_change_o(radial_change_o),
    .delta_x_o      (delta_x_o),
    .delta_y_o      (delta_y_o),
    .delta_z_o      (delta_z_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: mirrors the tracker's held positions and threshold.
  logic [31:0]        pr_deadband = DeadbandReset;
  logic signed [63:0] pr_step_pos [3];
  logic signed [63:0] pr_rad_pos  [3];
  logic signed [63:0] pr_ref      [3];
  logic signed [63:0] pr_hx, pr_hy, pr_hz;

  sample_t pending_items[$];
  motion_t expected_motion[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Floor square root of the squared Euclidean distance, bit by bit.
  function automatic logic [33:0] euclid_floor(input logic signed [63:0] a[3],
                                               input logic signed [63:0] b[3]);
    logic [65:0] acc;
    logic [65:0] d;
    logic [33:0] root;
    logic [33:0] trial;
    acc = '0;
    root = '0;
    for (int i = 0; i < 3; i++) begin
      d = (a[i] >= b[i]) ? 66'(a[i] - b[i]) : 66'(b[i] - a[i]);
      acc += d * d;
    end
    for (int bitpos = 33; bitpos >= 0; bitpos--) begin
      trial = root | (34'd1 << bitpos);
      if (68'(trial) * 68'(trial) <= 68'(acc)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Works out the result item of one accepted item and advances predictor state.
  function automatic motion_t track_motion(input sample_t s);
    motion_t r;
    logic signed [63:0] p[3];
    logic signed [63:0] th;
    logic signed [63:0] rn, ro, rc, dxv, dyv, dzv;
    logic [33:0] d;
    r = '{default: '0};
    p[0] = s.px;
    p[1] = s.py;
    p[2] = s.pz;
    th = {32'd0, pr_deadband};
    if (s.mode) begin
      for (int i = 0; i < 3; i++) begin
        if (s.mask[0]) pr_step_pos[i] = p[i];
        if (s.mask[1]) begin
          pr_ref[i] = p[i];
          pr_rad_pos[i] = p[i];
        end
      end
      if (s.mask[2]) pr_hy = p[1];
      if (s.mask[3]) pr_hx = p[0];
      if (s.mask[4]) pr_hz = p[2];
      return r;
    end
    d = euclid_floor(pr_step_pos, p);
    if (64'(d) > th) begin
      r.step = d;
      pr_step_pos = p;
    end
    rn = 64'(euclid_floor(p, pr_ref));
    ro = 64'(euclid_floor(pr_rad_pos, pr_ref));
    rc = rn - ro;
    if (abs64(rc) > th) begin
      r.radial = rc[34:0];
      pr_rad_pos = p;
    end
    dxv = p[0] - pr_hx;
    dyv = p[1] - pr_hy;
    dzv = p[2] - pr_hz;
    if (abs64(dxv) > th) begin
      r.dx = dxv[32:0];
      pr_hx = p[0];
    end
    if (abs64(dyv) > th) begin
      r.dy = dyv[32:0];
      pr_hy = p[1];
    end
    if (abs64(dzv) > th) begin
      r.dz = dzv[32:0];
      pr_hz = p[2];
    end
    return r;
  endfunction

  // Driver: offers the next pending item, holds it until accepted.
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      expected_motion.push_back(track_motion(pending_items.pop_front()));
    end
    if ((!in_valid || in_ready) && rst_ni) begin
      // the popped item is gone; decide whether to present the next one
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        mode_i        <= pending_items[0].mode;
        pos_x_i       <= pending_items[0].px;
        pos_y_i       <= pending_items[0].py;
        pos_z_i       <= pending_items[0].pz;
        rebase_mask_i <= pending_items[0].mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down once per cycle.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: random back-pressure plus an optional long hold-off.
  always @(posedge clk_i) begin
    motion_t e;
    if (out_valid && out_ready) begin
      if (expected_motion.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item step=%h", step_distance_o);
      end else begin
        e = expected_motion.pop_front();
        if (e.step !== step_distance_o || e.radial !== radial_change_o ||
            e.dx !== delta_x_o || e.dy !== delta_y_o || e.dz !== delta_z_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h %h %h got %h %h %h %h %h",
                     e.step, e.radial, e.dx, e.dy, e.dz, step_distance_o,
                     radial_change_o, delta_x_o, delta_y_o, delta_z_o);
        end
      end
    end
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic sample_t rand_item(input bit rebase);
    sample_t s;
    s.mode = rebase;
    s.mask = 5'($urandom_range(31));
    case ($urandom_range(3))
      0: begin
        s.px = $urandom;
        s.py = $urandom;
        s.pz = $urandom;
      end
      // small moves around the origin, near the deadband
      1: begin
        s.px = $signed($urandom_range(4000)) - 2000;
        s.py = $signed($urandom_range(4000)) - 2000;
        s.pz = $signed($urandom_range(4000)) - 2000;
      end
      2: begin
        s.px = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        s.py = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        s.pz = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      end
      default: begin
        s.px = $signed($urandom_range(1 << 20)) - (1 << 19);
        s.py = $signed($urandom_range(1 << 20)) - (1 << 19);
        s.pz = $signed($urandom_range(1 << 20)) - (1 << 19);
      end
    endcase
    return s;
  endfunction

  task automatic push_item(input logic m, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [4:0] k);
    sample_t s;
    s.mode = m;
    s.px = x;
    s.py = y;
    s.pz = z;
    s.mask = k;
    pending_items.push_back(s);
  endtask

  // Idle point: nothing pending or expected, then let the block settle.
  task automatic drain();
    while (pending_items.size() > 0 || expected_motion.size() > 0 || in_valid)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_deadband(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    pr_deadband <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned sp,
                              input int unsigned rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int i = 0; i < n; i++) pending_items.push_back(rand_item($urandom_range(5) == 0));
    drain();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      pr_step_pos[i] = 0;
      pr_rad_pos[i] = 0;
      pr_ref[i] = 0;
    end
    pr_hx = 0;
    pr_hy = 0;
    pr_hz = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset deadband, equal-threshold, extremes, rebase masks
    push_item(1'b0, 32'd655, 0, 0, 5'h1f);            // equal to deadband: zero
    push_item(1'b0, 32'd656, 0, 0, 0);                // just above
    push_item(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    push_item(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    push_item(1'b1, 32'h12345678, 32'hfedcba98, 32'h00010000, 5'h01);
    push_item(1'b1, 32'h00100000, 32'h00200000, 32'h00300000, 5'h02);
    push_item(1'b1, 32'hffff0000, 32'h00010000, 32'h7fffffff, 5'h04);
    push_item(1'b1, 32'h00050000, 0, 0, 5'h08);
    push_item(1'b1, 0, 0, 32'h80000000, 5'h10);
    push_item(1'b0, 0, 0, 0, 5'h1f);
    push_item(1'b1, 0, 0, 0, 5'h1f);
    push_item(1'b0, 32'hffffffff, 32'h00000001, 32'hfffffd71, 0);
    push_item(1'b0, 32'h80000000, 32'h7fffffff, 0, 0);
    drain();

    write_deadband(32'd0);
    push_item(1'b0, 1, 0, 0, 0);
    push_item(1'b0, 1, 0, 0, 0);
    push_item(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    drain();
    write_deadband(32'hffffffff);
    push_item(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    push_item(1'b0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    drain();
    write_deadband(32'd2000);

    random_phase(300, 11, 69);

    // long receiver hold-off while the sender keeps offering
    hold_off_cycles = 600;
    random_phase(20, 0, 0);

    write_deadband(32'h00010000);
    random_phase(300, 69, 11);
    write_deadband(DeadbandReset);
    random_phase(280, 0, 0);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
